FILE: sv/pce_pkg.sv
// shared types, constants and fixed-point helpers for the parabolic curve evaluator
`timescale 1ns / 1ps

package pce_pkg;

    // field and datapath widths
    localparam int RES_W     = 32;
    localparam int T_W       = 18;
    localparam int SPAN_W    = 33;
    localparam int ACC_W     = 66;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int NUM_STG   = 6;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);

    // register map, one word each
    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_X0    = 3'd0,
        REG_COEF_X1    = 3'd1,
        REG_COEF_X2    = 3'd2,
        REG_COEF_Y0    = 3'd3,
        REG_COEF_Y1    = 3'd4,
        REG_COEF_Y2    = 3'd5,
        REG_RANGE_LOW  = 3'd6,
        REG_RANGE_HIGH = 3'd7
    } reg_idx_e;

    typedef struct packed {
        logic [RES_W-1:0] coef_x0;
        logic [RES_W-1:0] coef_x1;
        logic [RES_W-1:0] coef_x2;
        logic [RES_W-1:0] coef_y0;
        logic [RES_W-1:0] coef_y1;
        logic [RES_W-1:0] coef_y2;
        logic [RES_W-1:0] range_low;
        logic [RES_W-1:0] range_high;
    } cfg_t;

    // polynomial terms of one axis
    typedef struct packed {
        logic [RES_W-1:0] c0;
        logic [RES_W-1:0] c1;
        logic [RES_W-1:0] c2;
    } axis_coef_t;

    // per-stage load enables
    typedef struct packed {
        logic [NUM_STG:1] en;
    } pipe_ctl_t;

    // one axis worth of results
    typedef struct packed {
        logic [RES_W-1:0] pos;
        logic [RES_W-1:0] slope;
        logic [RES_W-1:0] bend;
        logic             clip;
    } axis_res_t;

    typedef struct packed {
        logic [RES_W-1:0] val;
        logic             clip;
    } sat_t;

    // round half up by k bits, add a 32-bit term, saturate to 32 bits
    function automatic sat_t rnd_sat(input logic signed [ACC_W-1:0] v,
                                     input int unsigned k,
                                     input logic signed [RES_W-1:0] addend);
        logic signed [ACC_W-1:0] half;
        logic signed [ACC_W-1:0] sh;
        logic signed [ACC_W-1:0] ext;
        logic signed [ACC_W-1:0] sum;
        sat_t r;
        half = ACC_W'(1) << (k - 1);
        sh   = (v + half) >>> k;
        ext  = ACC_W'(addend);
        sum  = sh + ext;
        if (sum > SAT_MAX) begin
            r.val  = RES_W'(SAT_MAX);
            r.clip = 1'b1;
        end else if (sum < SAT_MIN) begin
            r.val  = RES_W'(SAT_MIN);
            r.clip = 1'b1;
        end else begin
            r.val  = sum[RES_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: sv/pce_cfg_regs.sv
// configuration register file behind the apb-style port
`timescale 1ns / 1ps

module pce_cfg_regs #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pce_pkg::ADDR_W-1:0]     paddr,
    input  logic [pce_pkg::RES_W-1:0]      pwdata,
    output logic [pce_pkg::RES_W-1:0]      prdata,
    output pce_pkg::cfg_t                  cfg
);

    localparam logic signed [pce_pkg::RES_W-1:0] ONE = pce_pkg::RES_W'(1) << FRAC_BITS;

    // coefficients zero, range [-1, 1]
    localparam pce_pkg::cfg_t CFG_RST = '{
        range_low:  -ONE,
        range_high: ONE,
        default:    '0
    };

    pce_pkg::cfg_t     cfg_reg;
    pce_pkg::cfg_t     cfg_next;
    pce_pkg::reg_idx_e idx;
    logic              wr_req;

    assign idx    = pce_pkg::reg_idx_e'(paddr[pce_pkg::ADDR_W-1:2]);
    assign wr_req = psel && penable && pwrite;

    // write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_req) begin
            case (idx)
                pce_pkg::REG_COEF_X0:    cfg_next.coef_x0    = pwdata;
                pce_pkg::REG_COEF_X1:    cfg_next.coef_x1    = pwdata;
                pce_pkg::REG_COEF_X2:    cfg_next.coef_x2    = pwdata;
                pce_pkg::REG_COEF_Y0:    cfg_next.coef_y0    = pwdata;
                pce_pkg::REG_COEF_Y1:    cfg_next.coef_y1    = pwdata;
                pce_pkg::REG_COEF_Y2:    cfg_next.coef_y2    = pwdata;
                pce_pkg::REG_RANGE_LOW:  cfg_next.range_low  = pwdata;
                pce_pkg::REG_RANGE_HIGH: cfg_next.range_high = pwdata;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // registers, range defaults to [-1, 1]
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb begin
        case (idx)
            pce_pkg::REG_COEF_X0:    prdata = cfg_reg.coef_x0;
            pce_pkg::REG_COEF_X1:    prdata = cfg_reg.coef_x1;
            pce_pkg::REG_COEF_X2:    prdata = cfg_reg.coef_x2;
            pce_pkg::REG_COEF_Y0:    prdata = cfg_reg.coef_y0;
            pce_pkg::REG_COEF_Y1:    prdata = cfg_reg.coef_y1;
            pce_pkg::REG_COEF_Y2:    prdata = cfg_reg.coef_y2;
            pce_pkg::REG_RANGE_LOW:  prdata = cfg_reg.range_low;
            pce_pkg::REG_RANGE_HIGH: prdata = cfg_reg.range_high;
            default:                 prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/pce_param.sv
// stages 1-2: map the reference parameter onto the configured curve range
`timescale 1ns / 1ps

module pce_param #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  pce_pkg::pipe_ctl_t                    ctl,
    input  logic signed [pce_pkg::SPAN_W-1:0]     span,
    input  logic signed [pce_pkg::SPAN_W-1:0]     mid2,
    input  logic signed [pce_pkg::T_W-1:0]        param_t,
    output logic signed [pce_pkg::RES_W-1:0]      s_out,
    output logic                                  s_clip
);

    localparam int AW = pce_pkg::ACC_W;
    localparam int PW = pce_pkg::SPAN_W + pce_pkg::T_W;

    logic signed [PW-1:0]               prod_reg;
    logic signed [AW-1:0]               sum;
    pce_pkg::sat_t                      s_next;
    logic signed [pce_pkg::RES_W-1:0]   s_reg;
    logic                               clip_reg;

    // stage 1: span * t
    always_ff @(posedge aclk) begin
        if (ctl.en[1]) begin
            prod_reg <= span * param_t;
        end
    end

    // stage 2: add the midpoint, round and clip
    assign sum    = AW'(prod_reg) + (AW'(mid2) <<< FRAC_BITS);
    assign s_next = pce_pkg::rnd_sat(sum, FRAC_BITS + 1, '0);

    always_ff @(posedge aclk) begin
        if (ctl.en[2]) begin
            s_reg    <= $signed(s_next.val);
            clip_reg <= s_next.clip;
        end
    end

    assign s_out  = s_reg;
    assign s_clip = clip_reg;

endmodule

FILE: sv/pce_axis.sv
// stages 1-6 of one axis: position, scaled slope and scaled bend
`timescale 1ns / 1ps

module pce_axis #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  pce_pkg::pipe_ctl_t                    ctl,
    input  pce_pkg::axis_coef_t                   coef,
    input  logic signed [pce_pkg::SPAN_W-1:0]     span,
    input  logic signed [pce_pkg::RES_W-1:0]      s_in,
    output pce_pkg::axis_res_t                    res
);

    localparam int AW = pce_pkg::ACC_W;
    localparam int RW = pce_pkg::RES_W;
    localparam int MW = 2 * RW;
    localparam int LW = RW + pce_pkg::SPAN_W;

    logic signed [RW-1:0] c0;
    logic signed [RW-1:0] c1;
    logic signed [RW-1:0] c2;

    logic signed [LW-1:0] cs_reg;
    pce_pkg::sat_t        w_next;
    logic signed [RW-1:0] w_reg;
    logic                 clip2_reg;

    logic signed [MW-1:0] cs2_reg;
    logic signed [LW-1:0] ws_reg;
    logic signed [RW-1:0] s3_reg;
    logic                 clip3_reg;

    pce_pkg::sat_t        p_next;
    pce_pkg::sat_t        d_next;
    pce_pkg::sat_t        b_next;
    logic signed [RW-1:0] p_reg;
    logic signed [RW-1:0] d_reg;
    logic [RW-1:0]        bend4_reg;
    logic signed [RW-1:0] s4_reg;
    logic                 clip4_reg;

    logic signed [MW-1:0] ps_reg;
    logic signed [LW-1:0] ds_reg;
    logic [RW-1:0]        bend5_reg;
    logic                 clip5_reg;

    pce_pkg::sat_t        pos_next;
    pce_pkg::sat_t        slope_next;
    pce_pkg::axis_res_t   res_reg;

    assign c0 = $signed(coef.c0);
    assign c1 = $signed(coef.c1);
    assign c2 = $signed(coef.c2);

    // stage 1: c2 * span
    always_ff @(posedge aclk) begin
        if (ctl.en[1]) begin
            cs_reg <= c2 * span;
        end
    end

    // stage 2: w = 2*c2*h, clipped
    assign w_next = pce_pkg::rnd_sat(AW'(cs_reg), FRAC_BITS, '0);

    always_ff @(posedge aclk) begin
        if (ctl.en[2]) begin
            w_reg     <= $signed(w_next.val);
            clip2_reg <= w_next.clip;
        end
    end

    // stage 3: c2 * s and w * span
    always_ff @(posedge aclk) begin
        if (ctl.en[3]) begin
            cs2_reg   <= c2 * s_in;
            ws_reg    <= w_reg * span;
            s3_reg    <= s_in;
            clip3_reg <= clip2_reg;
        end
    end

    // stage 4: inner horner term, derivative term, bend
    assign p_next = pce_pkg::rnd_sat(AW'(cs2_reg), FRAC_BITS, c1);
    assign d_next = pce_pkg::rnd_sat(AW'(cs2_reg), FRAC_BITS - 1, c1);
    assign b_next = pce_pkg::rnd_sat(AW'(ws_reg), FRAC_BITS + 1, '0);

    always_ff @(posedge aclk) begin
        if (ctl.en[4]) begin
            p_reg     <= $signed(p_next.val);
            d_reg     <= $signed(d_next.val);
            bend4_reg <= b_next.val;
            s4_reg    <= s3_reg;
            clip4_reg <= clip3_reg | p_next.clip | d_next.clip | b_next.clip;
        end
    end

    // stage 5: p * s and d * span
    always_ff @(posedge aclk) begin
        if (ctl.en[5]) begin
            ps_reg    <= p_reg * s4_reg;
            ds_reg    <= d_reg * span;
            bend5_reg <= bend4_reg;
            clip5_reg <= clip4_reg;
        end
    end

    // stage 6: position and slope, output register
    assign pos_next   = pce_pkg::rnd_sat(AW'(ps_reg), FRAC_BITS, c0);
    assign slope_next = pce_pkg::rnd_sat(AW'(ds_reg), FRAC_BITS + 1, '0);

    always_ff @(posedge aclk) begin
        if (ctl.en[6]) begin
            res_reg.pos   <= pos_next.val;
            res_reg.slope <= slope_next.val;
            res_reg.bend  <= bend5_reg;
            res_reg.clip  <= clip5_reg | pos_next.clip | slope_next.clip;
        end
    end

    assign res = res_reg;

endmodule

FILE: sv/parabolic_curve_evaluator.sv
// top level: quadratic curve point with derivatives scaled by the half range
// pipeline: one stage per multiply or round, from input request to result valid
// throughput: one item per cycle while the output is not stalled; each stage refills as soon as it hands its item on
// backpressure: an empty stage keeps loading while the output register waits
// reset: aresetn low clears all stage valid bits and sets coefficients to zero,
// range_low to -1.0 and range_high to +1.0
`timescale 1ns / 1ps

module parabolic_curve_evaluator #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: [17:0] param_t, [23:18] zero
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,
    // m_tdata: [31:0] pos_x, [63:32] pos_y, [95:64] slope_x, [127:96] slope_y,
    //          [159:128] bend_x, [191:160] bend_y
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [191:0]                   m_tdata,
    // m_tuser: [0] saturated
    output logic [0:0]                     m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pce_pkg::ADDR_W-1:0]     paddr,
    input  logic [pce_pkg::RES_W-1:0]      pwdata,
    output logic [pce_pkg::RES_W-1:0]      prdata,
    output logic                           pready
);

    localparam int N = pce_pkg::NUM_STG;

    pce_pkg::cfg_t                       cfg;
    pce_pkg::pipe_ctl_t                  ctl;
    pce_pkg::axis_coef_t                 coef_x;
    pce_pkg::axis_coef_t                 coef_y;
    pce_pkg::axis_res_t                  res_x;
    pce_pkg::axis_res_t                  res_y;
    logic signed [pce_pkg::SPAN_W-1:0]   span;
    logic signed [pce_pkg::SPAN_W-1:0]   mid2;
    logic signed [pce_pkg::RES_W-1:0]    s_val;
    logic                                s_clip;
    logic [N:1]                          vld_reg;
    logic [N:1]                          vld_next;
    logic [N:3]                          sclip_reg;

    assign pready = 1'b1;

    pce_cfg_regs #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // span and twice the midpoint, exact in 33 bits
    assign span = pce_pkg::SPAN_W'($signed(cfg.range_high))
                - pce_pkg::SPAN_W'($signed(cfg.range_low));
    assign mid2 = pce_pkg::SPAN_W'($signed(cfg.range_high))
                + pce_pkg::SPAN_W'($signed(cfg.range_low));

    assign coef_x = '{c0: cfg.coef_x0, c1: cfg.coef_x1, c2: cfg.coef_x2};
    assign coef_y = '{c0: cfg.coef_y0, c1: cfg.coef_y1, c2: cfg.coef_y2};

    // stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        ctl.en[N] = !vld_reg[N] || m_tready;
        for (int k = N - 1; k >= 1; k--) begin
            ctl.en[k] = !vld_reg[k] || ctl.en[k+1];
        end
    end

    always_comb begin
        vld_next[1] = ctl.en[1] ? s_tvalid : vld_reg[1];
        for (int k = 2; k <= N; k++) begin
            vld_next[k] = ctl.en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = ctl.en[1];

    pce_param #(
        .FRAC_BITS(FRAC_BITS)
    ) u_param (
        .aclk    (aclk),
        .ctl     (ctl),
        .span    (span),
        .mid2    (mid2),
        .param_t ($signed(s_tdata[pce_pkg::T_W-1:0])),
        .s_out   (s_val),
        .s_clip  (s_clip)
    );

    pce_axis #(
        .FRAC_BITS(FRAC_BITS)
    ) u_axis_x (
        .aclk (aclk),
        .ctl  (ctl),
        .coef (coef_x),
        .span (span),
        .s_in (s_val),
        .res  (res_x)
    );

    pce_axis #(
        .FRAC_BITS(FRAC_BITS)
    ) u_axis_y (
        .aclk (aclk),
        .ctl  (ctl),
        .coef (coef_y),
        .span (span),
        .s_in (s_val),
        .res  (res_y)
    );

    // carry the parameter clip flag down to the output stage
    always_ff @(posedge aclk) begin
        if (ctl.en[3]) begin
            sclip_reg[3] <= s_clip;
        end
        for (int k = 4; k <= N; k++) begin
            if (ctl.en[k]) begin
                sclip_reg[k] <= sclip_reg[k-1];
            end
        end
    end

    // result packing
    assign m_tvalid   = vld_reg[N];
    assign m_tdata    = {res_y.bend, res_x.bend, res_y.slope, res_x.slope,
                         res_y.pos, res_x.pos};
    assign m_tuser[0] = sclip_reg[N] | res_x.clip | res_y.clip;

    // an empty first stage always takes a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[1] |-> s_tready)
        else $error("input not ready while first stage empty");

    // a full pipe behind a stalled output refuses new requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg && !m_tready) |-> !s_tready)
        else $error("input accepted into a full stalled pipe");

    // a middle stage that cannot hand on its item keeps it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[3] && !ctl.en[4]) |=> vld_reg[3])
        else $error("stage three dropped an item under stall");

    // nothing is presented right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

FILE: verif/parabolic_curve_evaluator_tb.sv
// self-checking testbench for the parabolic curve evaluator: directed table, then random phases
`timescale 1ns / 1ps

module parabolic_curve_evaluator_tb;

    localparam int FRAC        = 16;
    localparam int NUM_DIR     = 22;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int STUCK_LIMIT = 2000;

    // wide enough for every product of the datapath
    typedef logic signed [79:0] wide_t;
    localparam wide_t LIM_HI = 80'sd2147483647;
    localparam wide_t LIM_LO = -LIM_HI - 80'sd1;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] slope_x;
        logic [31:0] slope_y;
        logic [31:0] bend_x;
        logic [31:0] bend_y;
        logic        saturated;
    } curve_res_t;

    // one directed request: register setting to use, parameter, optional typed result
    typedef struct packed {
        logic [2:0]  setting;
        logic [17:0] t;
        logic        known;
        curve_res_t  res;
    } dir_row_t;

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [23:0]    s_tdata;    // [17:0] param_t, [23:18] zero
    logic           m_tvalid;
    logic           m_tready;
    logic [191:0]   m_tdata;    // pos_x, pos_y, slope_x, slope_y, bend_x, bend_y from bit 0
    logic [0:0]     m_tuser;    // [0] saturated
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [pce_pkg::ADDR_W-1:0] paddr;
    logic [pce_pkg::RES_W-1:0]  pwdata;
    logic [pce_pkg::RES_W-1:0]  prdata;
    logic           pready;

    logic signed [31:0] cfg_regs [8];
    curve_res_t         points_due [$];
    curve_res_t         got_point;
    dir_row_t           dir_rows [NUM_DIR];
    logic [7:0][31:0]   setting_words [1:4];
    logic [7:0][31:0]   rand_words;

    bit src_stall_on;
    bit sink_stall_on;
    int sink_hold;
    int fail_count;
    int requests_sent;
    int results_seen;
    int sat_seen;
    int settings_applied;
    int stuck_cycles;

    parabolic_curve_evaluator #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // round half up by k bits
    function automatic wide_t rnd_shift(input wide_t v, input int k);
        wide_t half;
        half = 1;
        half = half <<< (k - 1);
        return (v + half) >>> k;
    endfunction

    // saturate to 32 bits, note any clipping
    function automatic wide_t clamp32(input wide_t v, inout bit clipped);
        if (v > LIM_HI) begin
            clipped = 1'b1;
            return LIM_HI;
        end
        if (v < LIM_LO) begin
            clipped = 1'b1;
            return LIM_LO;
        end
        return v;
    endfunction

    // position, scaled slope and scaled bend of one axis
    function automatic void eval_axis(input wide_t c0, input wide_t c1, input wide_t c2,
                                      input wide_t s, input wide_t span, inout bit clipped,
                                      output logic [31:0] pos, output logic [31:0] slope,
                                      output logic [31:0] bend);
        wide_t p;
        wide_t d;
        wide_t w;
        wide_t v;
        p = clamp32(c1 + rnd_shift(c2 * s, FRAC), clipped);
        d = clamp32(c1 + rnd_shift(c2 * s, FRAC - 1), clipped);
        w = clamp32(rnd_shift(c2 * span, FRAC), clipped);
        v = clamp32(c0 + rnd_shift(p * s, FRAC), clipped);
        pos = v[31:0];
        v = clamp32(rnd_shift(d * span, FRAC + 1), clipped);
        slope = v[31:0];
        v = clamp32(rnd_shift(w * span, FRAC + 1), clipped);
        bend = v[31:0];
    endfunction

    // expected curve point for one parameter under the current registers
    function automatic curve_res_t predict_curve(input logic [17:0] t_raw);
        logic signed [17:0] t_s;
        wide_t t;
        wide_t lo;
        wide_t hi;
        wide_t span;
        wide_t mid2;
        wide_t s;
        bit clipped;
        curve_res_t r;
        t_s = t_raw;
        t = t_s;
        lo = cfg_regs[pce_pkg::REG_RANGE_LOW];
        hi = cfg_regs[pce_pkg::REG_RANGE_HIGH];
        span = hi - lo;
        mid2 = hi + lo;
        clipped = 1'b0;
        s = clamp32(rnd_shift(span * t + (mid2 <<< FRAC), FRAC + 1), clipped);
        eval_axis(cfg_regs[pce_pkg::REG_COEF_X0], cfg_regs[pce_pkg::REG_COEF_X1],
                  cfg_regs[pce_pkg::REG_COEF_X2],
                  s, span, clipped, r.pos_x, r.slope_x, r.bend_x);
        eval_axis(cfg_regs[pce_pkg::REG_COEF_Y0], cfg_regs[pce_pkg::REG_COEF_Y1],
                  cfg_regs[pce_pkg::REG_COEF_Y2],
                  s, span, clipped, r.pos_y, r.slope_y, r.bend_y);
        r.saturated = clipped;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // coefficient word: extremes, full random or a moderate value
    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    // range end: mostly within a few units, sometimes extreme
    function automatic logic [31:0] rand_range_end();
        case ($urandom_range(0, 11))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    // parameter: mostly inside [-1,1], some anywhere in 18 bits, some at the ends
    function automatic logic [17:0] rand_param();
        case ($urandom_range(0, 9))
            0: return 18'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? 18'h10000 : 18'h30000;
            default: return 18'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    // write each register, then read it back
    task automatic apply_setting(input logic [7:0][31:0] words);
        for (int i = 0; i < 8; i++) begin
            pce_pkg::reg_idx_e idx;
            idx = pce_pkg::reg_idx_e'(i);
            psel = 1'b1;
            penable = 1'b0;
            pwrite = 1'b1;
            paddr = {idx, 2'b00};
            pwdata = words[i];
            @(negedge aclk);
            penable = 1'b1;
            do @(posedge aclk); while (!pready);
            cfg_regs[idx] = words[i];
            @(negedge aclk);
            penable = 1'b0;
            pwrite = 1'b0;
            @(negedge aclk);
            penable = 1'b1;
            do @(posedge aclk); while (!pready);
            check_field($sformatf("register %s", idx.name()), cfg_regs[idx], prdata);
            @(negedge aclk);
            psel = 1'b0;
            penable = 1'b0;
        end
        settings_applied++;
    endtask

    // one input request; called at a falling edge
    task automatic send_param(input logic [17:0] t, input logic known, input curve_res_t res);
        s_tvalid = 1'b1;
        s_tdata = {6'b0, t};
        do @(posedge aclk); while (!s_tready);
        points_due.push_back(known ? res : predict_curve(t));
        requests_sent++;
        @(negedge aclk);
        if (src_stall_on && $urandom_range(0, 99) < 25) begin
            s_tvalid = 1'b0;
            repeat (pick_gap()) @(negedge aclk);
        end
    endtask

    // block idle: all points returned and the pipeline flushed
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (points_due.size() != 0) @(negedge aclk);
        repeat (pce_pkg::NUM_STG + 2) @(negedge aclk);
    endtask

    // result side ready with random stalls
    initial begin
        m_tready = 1'b0;
        sink_hold = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_tready = 1'b0;
                sink_hold--;
            end else begin
                m_tready = 1'b1;
                if (sink_stall_on && $urandom_range(0, 99) < 20)
                    sink_hold = pick_gap();
            end
        end
    end

    // compare each returned point with the oldest one due
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser[0])
                sat_seen++;
            if (points_due.size() == 0) begin
                $error("result with no request pending: %h", m_tdata);
                fail_count++;
            end else begin
                got_point = points_due.pop_front();
                check_field("pos_x", got_point.pos_x, m_tdata[31:0]);
                check_field("pos_y", got_point.pos_y, m_tdata[63:32]);
                check_field("slope_x", got_point.slope_x, m_tdata[95:64]);
                check_field("slope_y", got_point.slope_y, m_tdata[127:96]);
                check_field("bend_x", got_point.bend_x, m_tdata[159:128]);
                check_field("bend_y", got_point.bend_y, m_tdata[191:160]);
                check_field("saturated", {31'b0, got_point.saturated}, {31'b0, m_tuser[0]});
            end
        end
    end

    // watchdog on cycles with no request moving on any port
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        src_stall_on = 1'b1;
        sink_stall_on = 1'b1;
        fail_count = 0;
        requests_sent = 0;
        results_seen = 0;
        sat_seen = 0;
        settings_applied = 0;
        stuck_cycles = 0;
        for (int i = 0; i < 8; i++)
            cfg_regs[i] = 0;
        cfg_regs[pce_pkg::REG_RANGE_LOW] = -65536;
        cfg_regs[pce_pkg::REG_RANGE_HIGH] = 65536;

        // moderate curve over [-4, 6]
        setting_words[1] = {32'h0006_0000, 32'hfffc_0000, 32'hfffe_c000, 32'h0000_8000,
                            32'hfffd_0000, 32'h0000_c000, 32'hfffe_0000, 32'h0001_8000};
        // reversed range, 3 down to -1
        setting_words[2] = {32'hffff_0000, 32'h0003_0000, 32'h0000_2000, 32'hffff_8000,
                            32'h0010_0000, 32'hffff_0000, 32'h0003_0000, 32'h0000_4000};
        // every word at an extreme, full range: clips everywhere
        setting_words[3] = {32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        // empty range at 2.0
        setting_words[4] = {32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_0000,
                            32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};

        // after reset every coefficient is zero, so every point is zero
        dir_rows = '{
            '{3'd0, 18'h00000, 1'b1, '0},
            '{3'd0, 18'h10000, 1'b1, '0},
            '{3'd0, 18'h30000, 1'b1, '0},
            '{3'd0, 18'h1ffff, 1'b1, '0},
            '{3'd0, 18'h20000, 1'b1, '0},
            '{3'd1, 18'h00000, 1'b0, '0},
            '{3'd1, 18'h00001, 1'b0, '0},
            '{3'd1, 18'h3ffff, 1'b0, '0},
            '{3'd1, 18'h10000, 1'b0, '0},
            '{3'd1, 18'h30000, 1'b0, '0},
            '{3'd2, 18'h08000, 1'b0, '0},
            '{3'd2, 18'h38000, 1'b0, '0},
            '{3'd2, 18'h10000, 1'b0, '0},
            '{3'd2, 18'h1ffff, 1'b0, '0},
            '{3'd3, 18'h00000, 1'b0, '0},
            '{3'd3, 18'h10000, 1'b0, '0},
            '{3'd3, 18'h30000, 1'b0, '0},
            '{3'd3, 18'h20000, 1'b0, '0},
            '{3'd3, 18'h0aaaa, 1'b0, '0},
            '{3'd4, 18'h00000, 1'b0, '0},
            '{3'd4, 18'h10000, 1'b0, '0},
            '{3'd4, 18'h3ffff, 1'b0, '0}
        };

        // hold reset low, then release it
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // directed table, switching settings between groups
        for (int i = 0; i < NUM_DIR; i++) begin
            if (dir_rows[i].setting != 3'd0 &&
                (i == 0 || dir_rows[i].setting != dir_rows[i - 1].setting)) begin
                wait_drained();
                apply_setting(setting_words[dir_rows[i].setting]);
            end
            send_param(dir_rows[i].t, dir_rows[i].known, dir_rows[i].res);
        end
        wait_drained();

        // random phases, each under a fresh register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            src_stall_on = (p % 3) != 0;
            sink_stall_on = (p % 4) != 0;
            for (int r = 0; r < 6; r++)
                rand_words[r] = rand_coef();
            rand_words[pce_pkg::REG_RANGE_LOW] = rand_range_end();
            rand_words[pce_pkg::REG_RANGE_HIGH] = rand_range_end();
            apply_setting(rand_words);
            repeat (PHASE_ITEMS) send_param(rand_param(), 1'b0, '0);
            wait_drained();
        end

        $display("covered %0d requests (%0d directed) under %0d register settings",
                 requests_sent, NUM_DIR, settings_applied + 1);
        $display("checked %0d points, %0d of them saturated, %0d mismatches",
                 results_seen, sat_seen, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
